>>> rtl/olpo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpo_pkg
// Request codes, status codes and sequencer types of the ordered list.
// ----------------------------------------------------------------------------
package olpo_pkg;

    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_AT    = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_AT    = 3'd5,
        FN_SEARCH    = 3'd6,
        FN_NOP       = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_UP   = 2'd0,
        OP_DOWN = 2'd1,
        OP_SRCH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_PUT  = 2'd2,
        S_FIN  = 2'd3
    } state_t;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 12;
    localparam int STATUS_W = 2;
    localparam int RES_W    = 9;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 24;

endpackage

>>> rtl/olpo_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpo_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olpo_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/olpo_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpo_seq
// Request sequencer: shifts entries one per cycle through the store, scans
// for searches, and holds the result register.
// ----------------------------------------------------------------------------
module olpo_seq #(
    parameter int CAPACITY = 256,
    parameter int ADDR_W   = 8,
    parameter int CNT_W    = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [olpo_pkg::FUNC_W-1:0]  in_func,
    input  logic [olpo_pkg::VALUE_W-1:0] in_value,
    input  logic [olpo_pkg::POS_W-1:0]   in_position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [olpo_pkg::OUT_W-1:0]   out_data,
    output logic                         mem_we,
    output logic [ADDR_W-1:0]            mem_waddr,
    output logic [olpo_pkg::VALUE_W-1:0] mem_wdata,
    output logic                         mem_re,
    output logic [ADDR_W-1:0]            mem_raddr,
    input  logic [olpo_pkg::VALUE_W-1:0] mem_rdata
);

    localparam int WW = (CNT_W > olpo_pkg::POS_W + 1) ? CNT_W : olpo_pkg::POS_W + 1;
    localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);

    olpo_pkg::state_t  state_reg, state_next;
    olpo_pkg::op_t     op_reg, op_next;
    olpo_pkg::status_t stat_reg, stat_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WW-1:0]     ptr_reg, ptr_next;
    logic [WW-1:0]     n_reg, n_next;
    logic [WW-1:0]     tgt_reg, tgt_next;
    logic [WW-1:0]     fpos_reg, fpos_next;
    logic              found_reg, found_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] paddr_reg, paddr_next;
    logic [olpo_pkg::VALUE_W-1:0] word_reg, word_next;
    logic              ovalid_reg, ovalid_next;
    logic [olpo_pkg::OUT_W-1:0] odata_reg, odata_next;

    logic [WW-1:0] cnt_w, idx_w, pos_w;
    logic          accept, load, run_done;

    assign in_ready  = (state_reg == olpo_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign load      = (state_reg == olpo_pkg::S_FIN) && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    assign cnt_w = WW'(count_reg);
    assign pos_w = WW'(in_position);
    assign idx_w = (pos_w <= WW'(1)) ? '0 : pos_w - WW'(1);

    always_comb
    begin
        case (op_reg)
            olpo_pkg::OP_SRCH: run_done = found_reg || (n_reg == '0 && !pend_reg);
            default:           run_done = (n_reg == '0) && !pend_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olpo_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = olpo_pkg::S_FIN;
                    case (olpo_pkg::func_t'(in_func))
                        olpo_pkg::FN_INS_FRONT, olpo_pkg::FN_INS_BACK, olpo_pkg::FN_INS_AT:
                            if (cnt_w < CAP_W) state_next = olpo_pkg::S_RUN;
                        olpo_pkg::FN_DEL_FRONT, olpo_pkg::FN_DEL_BACK:
                            if (cnt_w != '0) state_next = olpo_pkg::S_RUN;
                        olpo_pkg::FN_DEL_AT:
                            if (idx_w < cnt_w) state_next = olpo_pkg::S_RUN;
                        olpo_pkg::FN_SEARCH:
                            state_next = olpo_pkg::S_RUN;
                        default:
                            state_next = olpo_pkg::S_FIN;
                    endcase
                end
            end
            olpo_pkg::S_RUN:
            begin
                if (run_done)
                begin
                    state_next = (op_reg == olpo_pkg::OP_UP) ? olpo_pkg::S_PUT
                                                             : olpo_pkg::S_FIN;
                end
            end
            olpo_pkg::S_PUT: state_next = olpo_pkg::S_FIN;
            olpo_pkg::S_FIN: if (load) state_next = olpo_pkg::S_IDLE;
            default:         state_next = olpo_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        stat_next   = stat_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        n_next      = n_reg;
        tgt_next    = tgt_reg;
        fpos_next   = fpos_reg;
        found_next  = found_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        word_next   = word_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg && !out_ready;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = word_reg;
        mem_re      = 1'b0;
        mem_raddr   = ptr_reg[ADDR_W-1:0];

        case (state_reg)
            olpo_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    word_next  = in_value;
                    stat_next  = olpo_pkg::ST_DONE;
                    found_next = 1'b0;
                    fpos_next  = '0;
                    case (olpo_pkg::func_t'(in_func))
                        olpo_pkg::FN_INS_FRONT, olpo_pkg::FN_INS_BACK, olpo_pkg::FN_INS_AT:
                        begin
                            op_next = olpo_pkg::OP_UP;
                            if (in_func == olpo_pkg::FN_INS_FRONT) tgt_next = '0;
                            else if (in_func == olpo_pkg::FN_INS_BACK) tgt_next = cnt_w;
                            else tgt_next = (idx_w > cnt_w) ? cnt_w : idx_w;
                            if (cnt_w >= CAP_W) stat_next = olpo_pkg::ST_FULL;
                            ptr_next = cnt_w - WW'(1);
                            if (in_func == olpo_pkg::FN_INS_FRONT) n_next = cnt_w;
                            else if (in_func == olpo_pkg::FN_INS_BACK) n_next = '0;
                            else n_next = (idx_w > cnt_w) ? '0 : cnt_w - idx_w;
                        end
                        olpo_pkg::FN_DEL_FRONT, olpo_pkg::FN_DEL_BACK, olpo_pkg::FN_DEL_AT:
                        begin
                            op_next = olpo_pkg::OP_DOWN;
                            if (in_func == olpo_pkg::FN_DEL_FRONT) tgt_next = '0;
                            else if (in_func == olpo_pkg::FN_DEL_BACK) tgt_next = cnt_w - WW'(1);
                            else tgt_next = idx_w;
                            if (in_func == olpo_pkg::FN_DEL_AT)
                            begin
                                if (idx_w >= cnt_w) stat_next = olpo_pkg::ST_NONE;
                                ptr_next = idx_w + WW'(1);
                                n_next   = cnt_w - WW'(1) - idx_w;
                            end
                            else
                            begin
                                if (cnt_w == '0) stat_next = olpo_pkg::ST_NONE;
                                ptr_next = (in_func == olpo_pkg::FN_DEL_FRONT) ? WW'(1) : cnt_w;
                                n_next   = (in_func == olpo_pkg::FN_DEL_FRONT) ?
                                           cnt_w - WW'(1) : '0;
                            end
                        end
                        olpo_pkg::FN_SEARCH:
                        begin
                            op_next   = olpo_pkg::OP_SRCH;
                            stat_next = olpo_pkg::ST_MISS;
                            ptr_next  = '0;
                            n_next    = cnt_w;
                        end
                        default:
                        begin
                            op_next = olpo_pkg::OP_SRCH;
                        end
                    endcase
                end
            end
            olpo_pkg::S_RUN:
            begin
                if (pend_reg)
                begin
                    case (op_reg)
                        olpo_pkg::OP_UP:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = paddr_reg + ADDR_W'(1);
                            mem_wdata = mem_rdata;
                        end
                        olpo_pkg::OP_DOWN:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = paddr_reg - ADDR_W'(1);
                            mem_wdata = mem_rdata;
                        end
                        default:
                        begin
                            if (!found_reg && mem_rdata == word_reg)
                            begin
                                found_next = 1'b1;
                                stat_next  = olpo_pkg::ST_DONE;
                                fpos_next  = WW'(paddr_reg) + WW'(1);
                            end
                        end
                    endcase
                end
                if (n_reg != '0 && !found_reg)
                begin
                    mem_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg[ADDR_W-1:0];
                    n_next     = n_reg - WW'(1);
                    ptr_next   = (op_reg == olpo_pkg::OP_UP) ? ptr_reg - WW'(1)
                                                             : ptr_reg + WW'(1);
                end
                if (run_done && op_reg == olpo_pkg::OP_DOWN)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            olpo_pkg::S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = tgt_reg[ADDR_W-1:0];
                mem_wdata  = word_reg;
                count_next = count_reg + CNT_W'(1);
            end
            olpo_pkg::S_FIN:
            begin
                if (load)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {3'b000, olpo_pkg::RES_W'(count_reg),
                                   olpo_pkg::RES_W'(fpos_reg), found_reg, stat_reg};
                end
            end
            default:
            begin
                ovalid_next = ovalid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= olpo_pkg::S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        stat_reg  <= stat_next;
        ptr_reg   <= ptr_next;
        n_reg     <= n_next;
        tgt_reg   <= tgt_next;
        fpos_reg  <= fpos_next;
        found_reg <= found_next;
        paddr_reg <= paddr_next;
        word_reg  <= word_next;
        odata_reg <= odata_next;
    end

endmodule

>>> rtl/ordered_list_positional_ops_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_positional_ops_top
// Bounded ordered list of signed words kept packed in one entry store.
// ----------------------------------------------------------------------------
// One request at a time. Inserts and deletes shift the entries behind the
// target position through the store at one entry per cycle (one read, one
// write per cycle on its single write port), then an insert writes the new
// word; a search scans from the front at one entry per cycle and stops at the
// first match or at the end of the list. Refused inserts, empty or
// out-of-range deletes and the unused code skip the store and go straight
// to the result. The result waits in an output register while the next
// request is taken.
module ordered_list_positional_ops_top #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // func[2:0], value[34:3], position[46:35], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status[1:0], hit[2], found_position[11:3],
                                       // length[20:12], pad
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic                         mem_we, mem_re;
    logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
    logic [olpo_pkg::VALUE_W-1:0] mem_wdata, mem_rdata;

    olpo_seq #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_func     (s_axis_tdata[2:0]),
        .in_value    (s_axis_tdata[34:3]),
        .in_position (s_axis_tdata[46:35]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    olpo_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .DATA_W (olpo_pkg::VALUE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> rtl/olpo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpo_checker
// Port-level checks on the result stream of the ordered list.
// ----------------------------------------------------------------------------
module olpo_checker #(
    parameter int CAPACITY = 256
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic [1:0] status;
    logic       hit;
    logic [8:0] found;
    logic [8:0] length;

    assign status = m_axis_tdata[1:0];
    assign hit    = m_axis_tdata[2];
    assign found  = m_axis_tdata[11:3];
    assign length = m_axis_tdata[20:12];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && hit |-> status == olpo_pkg::ST_DONE && found != 9'd0
            && (CAPACITY > 511 || found <= length))
        else $error("hit without a valid position");

    a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !hit |-> found == 9'd0)
        else $error("position reported without a hit");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (CAPACITY > 511 || length <= 9'(CAPACITY)))
        else $error("length beyond capacity");

endmodule

bind ordered_list_positional_ops_top olpo_checker #(.CAPACITY(CAPACITY)) u_olpo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
